[rtl/core/lcd_pkg.sv]
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared codes and types of the locked LRU block cache directory.
// ----------------------------------------------------------------------------
package lcd_pkg;

	localparam int BLK_W = 32;
	localparam int OFF_W = 40;
	localparam int BYTES_W = 17;
	localparam int BUDGET_W = 21;

	localparam logic [2:0] CMD_FIND = 3'd0;
	localparam logic [2:0] CMD_LOAD = 3'd1;
	localparam logic [2:0] CMD_ZERO = 3'd2;
	localparam logic [2:0] CMD_UNLOCK = 3'd3;
	localparam logic [2:0] CMD_FLUSH = 3'd4;

	localparam logic [1:0] K_DONE = 2'd0;
	localparam logic [1:0] K_FETCH = 2'd1;
	localparam logic [1:0] K_CLEAN = 2'd2;
	localparam logic [1:0] K_WB = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_MISS = 3'd1;
	localparam logic [2:0] ST_PRESENT = 3'd2;
	localparam logic [2:0] ST_LOCKED = 3'd3;
	localparam logic [2:0] ST_UNKNOWN = 3'd4;
	localparam logic [2:0] ST_UNLOCKED = 3'd5;
	localparam logic [2:0] ST_FULL = 3'd6;

	// scan modes of the compare unit
	localparam logic [1:0] M_MATCH = 2'd0;
	localparam logic [1:0] M_OLDEST = 2'd1;
	localparam logic [1:0] M_MINDIRTY = 2'd2;

	typedef struct packed {
		logic [BLK_W-1:0] blk;
		logic [OFF_W-1:0] off;
		logic [BYTES_W-1:0] bytes;
	} entry_t;

	typedef struct packed {
		logic take;
		logic free;
	} cmp_res_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] status;
		logic [BLK_W-1:0] blk;
		logic [OFF_W-1:0] off;
		logic [BYTES_W-1:0] bytes;
		logic last;
	} res_t;

endpackage

[rtl/core/lcd_chan_if.sv]
// ----------------------------------------------------------------------------
// lcd_req_if / lcd_rsp_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface lcd_req_if import lcd_pkg::*; ();
	logic valid;
	logic ready;
	logic [2:0] command;
	logic [BLK_W-1:0] block_number;
	logic [OFF_W-1:0] file_offset;
	logic [BYTES_W-1:0] block_bytes;
	logic mark_dirty;

	modport source (output valid, command, block_number, file_offset, block_bytes,
		mark_dirty, input ready);
	modport sink (input valid, command, block_number, file_offset, block_bytes,
		mark_dirty, output ready);
endinterface

interface lcd_rsp_if import lcd_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [2:0] status;
	logic [BLK_W-1:0] out_block;
	logic [OFF_W-1:0] out_offset;
	logic [BYTES_W-1:0] out_bytes;
	logic last;

	modport source (output valid, kind, status, out_block, out_offset, out_bytes, last,
		input ready);
	modport sink (input valid, kind, status, out_block, out_offset, out_bytes, last,
		output ready);
endinterface

[rtl/core/locked_lru_block_cache_directory_top.sv]
// Find and insert end in a single result beat.
// Each entry scan reads the entry store one entry per cycle.
// Unlock emits one eviction beat per evicted entry before its final beat.
// Flush emits one writeback beat per dirty entry and then its final beat.
// One command at a time; results leave through a one-beat output register.
// Reset clears all entries, ages, byte count and sets the budget to 262144.
// ----------------------------------------------------------------------------
// locked_lru_block_cache_directory_top
// Sequencer of the block cache directory around a shared compare unit.
// ----------------------------------------------------------------------------
module locked_lru_block_cache_directory_top import lcd_pkg::*; #(
	parameter int ENTRIES = 16,
	parameter int MAX_BLOCK_BYTES = 65536
) (
	input logic clk,
	input logic arst_n,
	lcd_req_if.sink req,
	lcd_rsp_if.source rsp,
	input logic cfg_we,
	input logic [BUDGET_W-1:0] cfg_wdata
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int AW = IW;
	localparam int CTW = $clog2(ENTRIES + 1);
	localparam int UW0 = $clog2(ENTRIES * MAX_BLOCK_BYTES + 1);
	localparam int UW = (UW0 > BYTES_W) ? UW0 : BYTES_W;
	localparam int CW = (UW > BUDGET_W) ? UW : BUDGET_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_TRIM = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0] state_q, ret_q;
	logic [1:0] mode_q;
	logic [2:0] cmd_q;
	logic [BLK_W-1:0] blk_q;
	logic [OFF_W-1:0] off_q;
	logic [BYTES_W-1:0] bytes_q;
	logic mark_q;
	logic [CTW-1:0] cnt_q;
	logic v_s1;
	logic [IW-1:0] idx_s1;
	logic found_q, free_found_q;
	logic [IW-1:0] bidx_q, free_idx_q;
	logic [AW-1:0] bage_q;
	entry_t best_q;
	logic [ENTRIES-1:0] valid_q, dirty_q, locked_q;
	logic [AW-1:0] age_q [ENTRIES];
	logic [UW-1:0] used_q;
	logic [BUDGET_W-1:0] budget_q;
	res_t res_q, out_q;
	logic ovalid_q;

	logic [BYTES_W-1:0] in_bytes;
	logic mem_we, mem_re;
	entry_t mem_wdata, rd_data;
	cmp_res_t cmp;

	assign in_bytes = (32'(req.block_bytes) > 32'(MAX_BLOCK_BYTES)) ?
		BYTES_W'(MAX_BLOCK_BYTES) : req.block_bytes;

	assign mem_re = (state_q == S_SCAN) && (cnt_q < CTW'(ENTRIES));
	assign mem_we = (state_q == S_DECIDE) && (mode_q == M_MATCH) &&
		(cmd_q == CMD_LOAD || cmd_q == CMD_ZERO) && !found_q && free_found_q;
	assign mem_wdata = '{blk: blk_q, off: off_q, bytes: bytes_q};

	lcd_mem #(.DEPTH(ENTRIES), .IW(IW)) u_mem (
		.clk(clk), .we(mem_we), .waddr(free_idx_q), .wdata(mem_wdata),
		.re(mem_re), .raddr(cnt_q[IW-1:0]), .rdata(rd_data)
	);

	lcd_cmp #(.AW(AW)) u_cmp (
		.mode(mode_q), .key(blk_q), .rd_blk(rd_data.blk),
		.rd_valid(valid_q[idx_s1]), .rd_dirty(dirty_q[idx_s1]),
		.rd_locked(locked_q[idx_s1]), .rd_age(age_q[idx_s1]),
		.best_found(found_q), .best_age(bage_q), .best_blk(best_q.blk), .res(cmp)
	);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = ovalid_q;
	assign rsp.kind = out_q.kind;
	assign rsp.status = out_q.status;
	assign rsp.out_block = out_q.blk;
	assign rsp.out_offset = out_q.off;
	assign rsp.out_bytes = out_q.bytes;
	assign rsp.last = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_W'(262144);
		end else if (cfg_we) begin
			budget_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			cmd_q <= req.command;
			blk_q <= req.block_number;
			off_q <= req.file_offset;
			bytes_q <= in_bytes;
			mark_q <= req.mark_dirty;
		end
		if (state_q == S_EMIT && (!ovalid_q || rsp.ready)) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			mode_q <= M_MATCH;
			cnt_q <= '0;
			v_s1 <= 1'b0;
			idx_s1 <= '0;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			bidx_q <= '0;
			free_idx_q <= '0;
			bage_q <= '0;
			best_q <= '0;
			valid_q <= '0;
			dirty_q <= '0;
			locked_q <= '0;
			for (int j = 0; j < ENTRIES; j++) begin
				age_q[j] <= '0;
			end
			used_q <= '0;
			res_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						if (req.command == CMD_FLUSH) begin
							mode_q <= M_MINDIRTY;
							state_q <= S_START;
						end else if (req.command > CMD_FLUSH) begin
							res_q <= '{K_DONE, ST_OK, req.block_number, '0, '0, 1'b1};
							ret_q <= S_IDLE;
							state_q <= S_EMIT;
						end else begin
							mode_q <= M_MATCH;
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					cnt_q <= '0;
					v_s1 <= 1'b0;
					found_q <= 1'b0;
					free_found_q <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					v_s1 <= mem_re;
					idx_s1 <= cnt_q[IW-1:0];
					if (mem_re) begin
						cnt_q <= cnt_q + CTW'(1);
					end
					if (v_s1) begin
						if (cmp.take) begin
							found_q <= 1'b1;
							bidx_q <= idx_s1;
							bage_q <= age_q[idx_s1];
							best_q <= rd_data;
						end
						if (cmp.free && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q <= idx_s1;
						end
						if (idx_s1 == IW'(ENTRIES - 1)) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					state_q <= S_EMIT;
					ret_q <= S_IDLE;
					res_q <= '{K_DONE, ST_OK, blk_q, '0, '0, 1'b1};
					case (mode_q)
						M_MATCH: begin
							case (cmd_q)
								CMD_FIND: begin
									if (!found_q) begin
										res_q.status <= ST_MISS;
									end else if (locked_q[bidx_q]) begin
										res_q.status <= ST_LOCKED;
									end else begin
										for (int j = 0; j < ENTRIES; j++) begin
											if (IW'(j) != bidx_q && valid_q[j] && !locked_q[j] &&
												age_q[j] > age_q[bidx_q]) begin
												age_q[j] <= age_q[j] - AW'(1);
											end
										end
										age_q[bidx_q] <= '0;
										locked_q[bidx_q] <= 1'b1;
										res_q.off <= best_q.off;
										res_q.bytes <= best_q.bytes;
									end
								end
								CMD_LOAD, CMD_ZERO: begin
									if (found_q) begin
										res_q.status <= locked_q[bidx_q] ? ST_LOCKED : ST_PRESENT;
									end else if (!free_found_q) begin
										res_q.status <= ST_FULL;
									end else begin
										valid_q[free_idx_q] <= 1'b1;
										dirty_q[free_idx_q] <= 1'b0;
										locked_q[free_idx_q] <= 1'b1;
										age_q[free_idx_q] <= '0;
										used_q <= used_q + UW'(bytes_q);
										if (cmd_q == CMD_LOAD) begin
											res_q.kind <= K_FETCH;
											res_q.off <= off_q;
											res_q.bytes <= bytes_q;
										end
									end
								end
								CMD_UNLOCK: begin
									if (!found_q) begin
										res_q.status <= ST_UNKNOWN;
									end else if (!locked_q[bidx_q]) begin
										res_q.status <= ST_UNLOCKED;
									end else begin
										// newest unlocked: age the rest
										for (int j = 0; j < ENTRIES; j++) begin
											if (IW'(j) != bidx_q && valid_q[j] && !locked_q[j]) begin
												age_q[j] <= age_q[j] + AW'(1);
											end
										end
										age_q[bidx_q] <= '0;
										locked_q[bidx_q] <= 1'b0;
										if (mark_q) begin
											dirty_q[bidx_q] <= 1'b1;
										end
										state_q <= S_TRIM;
									end
								end
								default: ;
							endcase
						end
						M_OLDEST: begin
							if (!found_q) begin
								res_q.status <= ST_FULL;
							end else begin
								// evict the oldest unlocked entry
								res_q <= '{dirty_q[bidx_q] ? K_WB : K_CLEAN, ST_OK, best_q.blk,
									best_q.off, best_q.bytes, 1'b0};
								ret_q <= S_TRIM;
								for (int j = 0; j < ENTRIES; j++) begin
									if (IW'(j) != bidx_q && valid_q[j] && !locked_q[j] &&
										age_q[j] > age_q[bidx_q]) begin
										age_q[j] <= age_q[j] - AW'(1);
									end
								end
								age_q[bidx_q] <= '0;
								valid_q[bidx_q] <= 1'b0;
								dirty_q[bidx_q] <= 1'b0;
								used_q <= used_q - UW'(best_q.bytes);
							end
						end
						M_MINDIRTY: begin
							if (found_q) begin
								res_q <= '{K_WB, ST_OK, best_q.blk, best_q.off, best_q.bytes, 1'b0};
								dirty_q[bidx_q] <= 1'b0;
								ret_q <= S_START;
							end
						end
						default: ;
					endcase
				end
				S_TRIM: begin
					if (CW'(used_q) > CW'(budget_q)) begin
						mode_q <= M_OLDEST;
						state_q <= S_START;
					end else begin
						res_q <= '{K_DONE, ST_OK, blk_q, '0, '0, 1'b1};
						ret_q <= S_IDLE;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!ovalid_q || rsp.ready) begin
						ovalid_q <= 1'b1;
						state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("accepted a command while busy");
	a_stage_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == S_SCAN || state_q == S_DECIDE))
		else $error("scan stage outside scan");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= 32'(ENTRIES * MAX_BLOCK_BYTES))
		else $error("byte count out of range");
	a_insert_free: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !valid_q[free_idx_q])
		else $error("insert over a valid entry");
`endif
endmodule

[rtl/core/lcd_mem.sv]
// ----------------------------------------------------------------------------
// lcd_mem
// Entry store: block, offset and size, one write and one registered read port.
// ----------------------------------------------------------------------------
module lcd_mem import lcd_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int IW = 4
) (
	input logic clk,
	input logic we,
	input logic [IW-1:0] waddr,
	input entry_t wdata,
	input logic re,
	input logic [IW-1:0] raddr,
	output entry_t rdata
);
	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/core/lcd_cmp.sv]
// ----------------------------------------------------------------------------
// lcd_cmp
// Shared compare unit: judges one scanned entry against the key or best so far.
// ----------------------------------------------------------------------------
module lcd_cmp import lcd_pkg::*; #(
	parameter int AW = 4
) (
	input logic [1:0] mode,
	input logic [BLK_W-1:0] key,
	input logic [BLK_W-1:0] rd_blk,
	input logic rd_valid,
	input logic rd_dirty,
	input logic rd_locked,
	input logic [AW-1:0] rd_age,
	input logic best_found,
	input logic [AW-1:0] best_age,
	input logic [BLK_W-1:0] best_blk,
	output cmp_res_t res
);
	logic [BLK_W-1:0] b;
	logic eq, lt;

	always_comb begin
		b = (mode == M_MATCH) ? key : best_blk;
		eq = (rd_blk == b);
		lt = (rd_blk < b);
		res.free = !rd_valid;
		case (mode)
			M_MATCH: res.take = rd_valid && eq && !best_found;
			M_OLDEST: res.take = rd_valid && !rd_locked && (!best_found || rd_age > best_age);
			M_MINDIRTY: res.take = rd_valid && rd_dirty && (!best_found || lt);
			default: res.take = 1'b0;
		endcase
	end
endmodule

[bench/tb_chan_if.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chan_if
// Bench package: the command beat that the bench drives and predicts from.
// ----------------------------------------------------------------------------
package tb_dir_pkg;
	import lcd_pkg::*;

	typedef struct {
		logic [2:0] cmd;
		logic [BLK_W-1:0] blk;
		logic [OFF_W-1:0] off;
		logic [BYTES_W-1:0] bytes;
		logic mark;
	} cmd_beat_t;
endpackage

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed rows and random command sequences into the cache directory,
// predicts every result beat from a bench-side copy of the table and checks
// them in order, under random idling on both channels and long back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
	import lcd_pkg::*;
	import tb_dir_pkg::*;

	localparam int NENT = 16;
	localparam int MAXB = 65536;
	localparam longint LIMIT = 1000000;

	logic clk, arst_n, cfg_we;
	logic [BUDGET_W-1:0] cfg_wdata;
	lcd_req_if req ();
	lcd_rsp_if rsp ();

	locked_lru_block_cache_directory_top i_dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// bench copy of the directory
	logic [BUDGET_W-1:0] budget;
	logic v_q[NENT], d_q[NENT], l_q[NENT];
	logic [BLK_W-1:0] b_q[NENT];
	logic [OFF_W-1:0] o_q[NENT];
	logic [BYTES_W-1:0] s_q[NENT];
	int age_q[NENT];
	longint in_use;

	res_t pending[$];
	int errors;
	longint cycles;
	int hold_long;
	logic [BLK_W-1:0] pool[8];

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic report(string what, res_t g, res_t e);
		errors++;
		$display({"mismatch %s: got %0d/%0d blk %h off %h b %h l %0d,",
			" exp %0d/%0d blk %h off %h b %h l %0d"},
			what, g.kind, g.status, g.blk, g.off, g.bytes, g.last,
			e.kind, e.status, e.blk, e.off, e.bytes, e.last);
	endtask

	function automatic res_t mk(logic [1:0] k, logic [2:0] s, logic [BLK_W-1:0] b,
		logic [OFF_W-1:0] o, logic [BYTES_W-1:0] n, logic l);
		res_t r;
		r.kind = k; r.status = s; r.blk = b; r.off = o; r.bytes = n; r.last = l;
		return r;
	endfunction

	function automatic bit lru(int j);
		return v_q[j] && !l_q[j];
	endfunction

	function automatic int find_slot(logic [BLK_W-1:0] b);
		for (int i = 0; i < NENT; i++)
			if (v_q[i] && b_q[i] == b) return i;
		return -1;
	endfunction

	task automatic drop_from_lru(int i);
		for (int j = 0; j < NENT; j++)
			if (j != i && lru(j) && age_q[j] > age_q[i]) age_q[j]--;
		age_q[i] = 0;
	endtask

	// compute the result beats of one command and queue them
	task automatic predict_dir(cmd_beat_t c);
		int i, j, best;
		logic [2:0] st;
		logic [BYTES_W-1:0] n;
		n = (c.bytes > MAXB) ? BYTES_W'(MAXB) : c.bytes;
		case (c.cmd)
			CMD_FIND: begin
				i = find_slot(c.blk);
				if (i < 0) pending.push_back(mk(K_DONE, ST_MISS, c.blk, 0, 0, 1));
				else if (l_q[i]) pending.push_back(mk(K_DONE, ST_LOCKED, c.blk, 0, 0, 1));
				else begin
					drop_from_lru(i);
					l_q[i] = 1;
					pending.push_back(mk(K_DONE, ST_OK, c.blk, o_q[i], s_q[i], 1));
				end
			end
			CMD_LOAD, CMD_ZERO: begin
				i = find_slot(c.blk);
				j = 0;
				while (j < NENT && v_q[j]) j++;
				if (i >= 0)
					pending.push_back(mk(K_DONE, l_q[i] ? ST_LOCKED : ST_PRESENT, c.blk, 0, 0, 1));
				else if (j >= NENT) pending.push_back(mk(K_DONE, ST_FULL, c.blk, 0, 0, 1));
				else begin
					v_q[j] = 1; b_q[j] = c.blk; o_q[j] = c.off; s_q[j] = n;
					d_q[j] = 0; l_q[j] = 1; age_q[j] = 0;
					in_use += n;
					if (c.cmd == CMD_LOAD) pending.push_back(mk(K_FETCH, ST_OK, c.blk, c.off, n, 1));
					else pending.push_back(mk(K_DONE, ST_OK, c.blk, 0, 0, 1));
				end
			end
			CMD_UNLOCK: begin
				i = find_slot(c.blk);
				st = ST_OK;
				if (i < 0) pending.push_back(mk(K_DONE, ST_UNKNOWN, c.blk, 0, 0, 1));
				else if (!l_q[i]) pending.push_back(mk(K_DONE, ST_UNLOCKED, c.blk, 0, 0, 1));
				else begin
					for (j = 0; j < NENT; j++)
						if (j != i && lru(j)) age_q[j]++;
					age_q[i] = 0; l_q[i] = 0;
					if (c.mark) d_q[i] = 1;
					while (in_use > budget) begin
						best = -1;
						for (j = 0; j < NENT; j++)
							if (lru(j) && (best < 0 || age_q[j] > age_q[best])) best = j;
						if (best < 0) begin
							st = ST_FULL;
							break;
						end
						pending.push_back(mk(d_q[best] ? K_WB : K_CLEAN, ST_OK, b_q[best],
							o_q[best], s_q[best], 0));
						drop_from_lru(best);
						v_q[best] = 0; d_q[best] = 0;
						in_use -= s_q[best];
					end
					pending.push_back(mk(K_DONE, st, c.blk, 0, 0, 1));
				end
			end
			CMD_FLUSH: begin
				forever begin
					best = -1;
					for (j = 0; j < NENT; j++)
						if (v_q[j] && d_q[j] && (best < 0 || b_q[j] < b_q[best])) best = j;
					if (best < 0) break;
					pending.push_back(mk(K_WB, ST_OK, b_q[best], o_q[best], s_q[best], 0));
					d_q[best] = 0;
				end
				pending.push_back(mk(K_DONE, ST_OK, c.blk, 0, 0, 1));
			end
			default: pending.push_back(mk(K_DONE, ST_OK, c.blk, 0, 0, 1));
		endcase
	endtask

	// send one command beat after a random gap, then predict; valid stays up
	// until the next gap or a drain drops it
	task automatic send_cmd(cmd_beat_t c);
		int gap;
		gap = $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			req.valid <= 0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1;
		req.command <= c.cmd; req.block_number <= c.blk; req.file_offset <= c.off;
		req.block_bytes <= c.bytes; req.mark_dirty <= c.mark;
		do @(posedge clk); while (!req.ready);
		predict_dir(c);
	endtask

	task automatic drain();
		@(negedge clk);
		req.valid <= 0;
		while (pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_budget(logic [BUDGET_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_we <= 1; cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		budget = v;
	endtask

	function automatic cmd_beat_t row(logic [2:0] c, logic [BLK_W-1:0] b,
		logic [OFF_W-1:0] o, logic [BYTES_W-1:0] n, logic m);
		cmd_beat_t r;
		r.cmd = c; r.blk = b; r.off = o; r.bytes = n; r.mark = m;
		return r;
	endfunction

	function automatic cmd_beat_t rand_beat();
		cmd_beat_t c;
		int p;
		p = $urandom_range(0, 99);
		c.blk = (p < 90) ? pool[$urandom_range(0, 7)] : $urandom;
		c.off = OFF_W'({$urandom, $urandom});
		p = $urandom_range(0, 9);
		c.bytes = (p == 0) ? BYTES_W'($urandom) : (p == 1) ? BYTES_W'(MAXB)
			: BYTES_W'($urandom_range(0, 40000));
		c.mark = 1'($urandom_range(0, 1));
		p = $urandom_range(0, 99);
		c.cmd = (p < 25) ? CMD_FIND : (p < 40) ? CMD_LOAD : (p < 50) ? CMD_ZERO
			: (p < 85) ? CMD_UNLOCK : (p < 95) ? CMD_FLUSH : 3'($urandom_range(5, 7));
		return c;
	endfunction

	// response side: random stalls, one long hold-off on request
	initial begin
		res_t g, e;
		int gap;
		rsp.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_long > 0) begin
				rsp.ready <= 0;
				repeat (hold_long) @(negedge clk);
				hold_long = 0;
			end else begin
				gap = $urandom_range(0, 6);
				if (gap > 0) begin
					rsp.ready <= 0;
					repeat (gap) @(negedge clk);
				end
			end
			rsp.ready <= 1;
			do @(posedge clk); while (!rsp.valid);
			g = mk(rsp.kind, rsp.status, rsp.out_block, rsp.out_offset, rsp.out_bytes, rsp.last);
			if (pending.size() == 0) report("unexpected", g, g);
			else begin
				e = pending.pop_front();
				if (g != e) report("field", g, e);
			end
		end
	end

	// directed rows; the first expected beat is typed, the rest come from the predictor
	cmd_beat_t drows[$];
	initial begin
		cmd_beat_t c;
		res_t e;
		errors = 0; cycles = 0; hold_long = 0;
		arst_n = 0; cfg_we = 0; cfg_wdata = 0;
		req.valid = 0; req.command = 0; req.block_number = 0; req.file_offset = 0;
		req.block_bytes = 0; req.mark_dirty = 0;
		budget = 262144; in_use = 0;
		for (int i = 0; i < NENT; i++) begin
			v_q[i] = 0; d_q[i] = 0; l_q[i] = 0; b_q[i] = 0; o_q[i] = 0; s_q[i] = 0;
			age_q[i] = 0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// after reset: miss, unknown, empty flush, unknown command
		e = mk(K_DONE, ST_MISS, 32'hFFFFFFFF, 0, 0, 1);
		send_cmd(row(CMD_FIND, 32'hFFFFFFFF, 0, 0, 0));
		if (pending[pending.size()-1] != e) report("directed", pending[pending.size()-1], e);
		send_cmd(row(CMD_UNLOCK, 0, 0, 0, 1));
		send_cmd(row(CMD_FLUSH, 32'h1234, 0, 0, 0));
		send_cmd(row(3'd7, 32'hA5A5A5A5, 40'hFF_FFFF_FFFF, 17'h1FFFF, 1));
		drows.push_back(row(CMD_LOAD, 0, 40'hFF_FFFF_FFFF, 17'h1FFFF, 0)); // saturate
		drows.push_back(row(CMD_LOAD, 0, 0, 0, 0));          // locked present
		drows.push_back(row(CMD_FIND, 0, 0, 0, 0));          // find locked
		drows.push_back(row(CMD_ZERO, 32'hFFFFFFFF, 40'h5, 0, 0));
		drows.push_back(row(CMD_UNLOCK, 0, 0, 0, 1));
		drows.push_back(row(CMD_UNLOCK, 0, 0, 0, 0));        // already unlocked
		drows.push_back(row(CMD_ZERO, 0, 0, 0, 0));          // present unlocked
		drows.push_back(row(CMD_FIND, 0, 0, 0, 0));          // hit
		drows.push_back(row(CMD_UNLOCK, 0, 0, 0, 0));
		drows.push_back(row(CMD_FLUSH, 0, 0, 0, 0));
		for (int i = 1; i < 16; i++)
			drows.push_back(row(CMD_ZERO, BLK_W'(i), OFF_W'(i), 17'd1000, 0));
		drows.push_back(row(CMD_LOAD, 99, 0, 17'd10, 0));    // table full
		foreach (drows[k]) send_cmd(drows[k]);
		// tiny budget: unlocks evict; stuck over budget while others locked
		set_budget(0);
		send_cmd(row(CMD_UNLOCK, 1, 0, 0, 1));
		send_cmd(row(CMD_UNLOCK, 2, 0, 0, 0));
		set_budget(21'h1FFFFF);
		for (int i = 3; i < 16; i++) send_cmd(row(CMD_UNLOCK, BLK_W'(i), 0, 0, i[0]));
		send_cmd(row(CMD_FLUSH, 7, 0, 0, 0));
		set_budget(21'(1048576));
		for (int i = 0; i < 8; i++) pool[i] = (i < 4) ? i : $urandom;
		for (int n = 0; n < 324; n++) begin
			if (n == 90) set_budget(21'($urandom_range(0, 100000)));
			if (n == 180) set_budget(21'($urandom_range(60000, 200000)));
			if (n == 270) set_budget(0);
			if (n == 120) hold_long = 400;
			if (n == 200) drain();
			if (n % 60 == 0) pool[$urandom_range(0, 7)] = $urandom;
			send_cmd(rand_beat());
		end
		drain();
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule

[filelist.f]
rtl/core/lcd_pkg.sv
rtl/core/lcd_chan_if.sv
rtl/core/lcd_mem.sv
rtl/core/lcd_cmp.sv
rtl/core/locked_lru_block_cache_directory_top.sv
bench/tb_chan_if.sv
bench/tb_top.sv
